### hdl/utf8js_pkg.sv
`default_nettype none
package utf8js_pkg;

    // A group holds every result byte that one input byte causes.
    localparam int GRP_MAX   = 5;
    localparam int GRP_CNT_W = $clog2(GRP_MAX + 1);
    localparam int GRP_IDX_W = $clog2(GRP_MAX);

    // Decoupling queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_REPLACE = 8'h3F;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_N       = 8'h6E;
    localparam logic [7:0] CHAR_R       = 8'h72;
    localparam logic [7:0] CHAR_T       = 8'h74;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DEL     = 8'h7F;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] CONT_LO  = 8'h80;
    localparam logic [7:0] CONT_HI  = 8'hBF;

    typedef struct packed {
        logic [GRP_MAX-1:0][7:0] data;
        logic [GRP_CNT_W-1:0]    cnt;
        logic                    text_end;
    } utf8js_group_t;

endpackage
`default_nettype wire

### hdl/utf8js_front.sv
`default_nettype none
module utf8js_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    text_end,
    input  wire logic                    cfg_write,
    input  wire logic                    cfg_mode,
    output logic                         push,
    output utf8js_pkg::utf8js_group_t    grp
);
    import utf8js_pkg::*;

    logic       mode_reg;
    logic [7:0] lead_reg, lead_next;
    logic [1:0] need_reg, need_next;
    logic [1:0] count_reg, count_next;
    logic [7:0] follow_reg [2];

    logic [7:0] f0, f1;
    logic [1:0] fn;
    logic       f_start;
    logic [1:0] f_need;
    logic       is_cont, pending, complete, hold, broken;
    logic [2:0] p;

    // Classify the byte as if nothing were held.
    always_comb
    begin
        f0      = in_byte;
        f1      = in_byte;
        fn      = 2'd1;
        f_start = 1'b0;
        f_need  = 2'd0;
        if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI)
            f_need = 2'd1;
        else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI)
            f_need = 2'd2;
        else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI)
            f_need = 2'd3;
        if (in_byte[7])
        begin
            if (f_need == 2'd0 || text_end)
                f0 = CHAR_REPLACE;
            else
            begin
                f_start = 1'b1;
                fn      = 2'd0;
            end
        end
        else if (mode_reg && (in_byte == CHAR_QUOTE || in_byte == CHAR_BSLASH))
        begin
            f0 = CHAR_BSLASH;
            fn = 2'd2;
        end
        else if (mode_reg && in_byte == CHAR_LF)
        begin
            f0 = CHAR_BSLASH;
            f1 = CHAR_N;
            fn = 2'd2;
        end
        else if (mode_reg && in_byte == CHAR_CR)
        begin
            f0 = CHAR_BSLASH;
            f1 = CHAR_R;
            fn = 2'd2;
        end
        else if (mode_reg && in_byte == CHAR_TAB)
        begin
            f0 = CHAR_BSLASH;
            f1 = CHAR_T;
            fn = 2'd2;
        end
        else if (in_byte < CHAR_SPACE || in_byte == CHAR_DEL)
            f0 = CHAR_REPLACE;
    end

    always_comb
    begin
        is_cont  = (in_byte >= CONT_LO) && (in_byte <= CONT_HI);
        pending  = (need_reg != 2'd0);
        complete = pending && is_cont && (({1'b0, count_reg} + 3'd1) >= {1'b0, need_reg});
        hold     = pending && is_cont && !complete && !text_end;
        broken   = pending && !complete && !hold;
        p        = broken ? ({1'b0, count_reg} + 3'd1) : 3'd0;
    end

    // Assemble the result word group.
    always_comb
    begin
        grp.data     = '0;
        grp.text_end = text_end;
        if (complete)
        begin
            grp.cnt     = GRP_CNT_W'({1'b0, count_reg} + 3'd2);
            grp.data[0] = lead_reg;
            case (count_reg)
                2'd0:
                begin
                    grp.data[1] = in_byte;
                end
                2'd1:
                begin
                    grp.data[1] = follow_reg[0];
                    grp.data[2] = in_byte;
                end
                default:
                begin
                    grp.data[1] = follow_reg[0];
                    grp.data[2] = follow_reg[1];
                    grp.data[3] = in_byte;
                end
            endcase
        end
        else if (hold)
            grp.cnt = '0;
        else
        begin
            grp.cnt = GRP_CNT_W'(p + {1'b0, fn});
            for (int i = 0; i < GRP_MAX; i++)
            begin
                if (3'(i) < p)
                    grp.data[i] = CHAR_REPLACE;
                else if (3'(i) == p)
                    grp.data[i] = f0;
                else
                    grp.data[i] = f1;
            end
        end
        push = accept && (grp.cnt != '0);
    end

    always_comb
    begin
        lead_next  = lead_reg;
        need_next  = need_reg;
        count_next = count_reg;
        if (complete)
        begin
            lead_next  = '0;
            need_next  = '0;
            count_next = '0;
        end
        else if (hold)
            count_next = count_reg + 2'd1;
        else if (f_start)
        begin
            lead_next  = in_byte;
            need_next  = f_need;
            count_next = '0;
        end
        else
        begin
            lead_next  = '0;
            need_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            lead_reg  <= '0;
            need_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                mode_reg <= cfg_mode;
            if (accept)
            begin
                lead_reg  <= lead_next;
                need_reg  <= need_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold)
            follow_reg[count_reg[0]] <= in_byte;
    end

    a_count_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        need_reg != 2'd0 |-> count_reg < need_reg)
        else $error("held follower count reached the needed count");

endmodule
`default_nettype wire

### hdl/utf8js_queue.sv
`default_nettype none
module utf8js_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire utf8js_pkg::utf8js_group_t push_grp,
    input  wire logic                    pop,
    output logic                         full,
    output logic                         not_empty,
    output utf8js_pkg::utf8js_group_t    head
);
    import utf8js_pkg::*;

    utf8js_group_t       mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_grp;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("word group pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count lost a push");

endmodule
`default_nettype wire

### hdl/utf8js_back.sv
`default_nettype none
module utf8js_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire utf8js_pkg::utf8js_group_t head,
    output logic                         pop,
    input  wire logic                    out_stall,
    output logic                         out_valid,
    output logic [7:0]                   out_byte,
    output logic                         run_last,
    output logic                         text_done
);
    import utf8js_pkg::*;

    logic [GRP_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 run_last_reg;
    logic                 text_done_reg;
    logic                 load;
    logic                 is_last;

    assign load    = q_valid && (!out_valid_reg || !out_stall);
    assign is_last = (GRP_CNT_W'(idx_reg) + 1'b1) == head.cnt;
    assign pop     = load && is_last;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign text_done = text_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? '0 : idx_reg + 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload loads with the word, holds while stalled.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= head.data[idx_reg];
            run_last_reg  <= is_last;
            text_done_reg <= is_last && head.text_end;
        end
    end

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && text_done_reg |-> run_last_reg)
        else $error("text end flagged on a word that is not the last of its group");

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> GRP_CNT_W'(idx_reg) < head.cnt)
        else $error("group index ran past the group length");

endmodule
`default_nettype wire

### hdl/utf8_json_escape_sanitizer_core.sv
// Channel   Ports                                         Handshake
// ------------------------------------------------------------------------------
// input     in_byte[7:0], text_end                        in_valid / in_stall
// output    out_byte[7:0], run_last, text_done            out_valid / out_stall
// config    escape_mode                                   cfg_valid / cfg_ready
//
// One input byte is taken per cycle while the two-group queue has room; its 0 to 5
// result words enter the queue as one group in the same cycle.
// While out_stall is low, the back end emits one word per cycle from the queue head through
// the output register, so the sustained rate is set by the number of result words per byte.
// Reset clears the held sequence, the queue and out_valid; escape_mode resets to 1.
// out_stall halts only the back end; in_stall rises when the queue holds two groups.
`default_nettype none
module utf8_json_escape_sanitizer_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       text_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            text_done,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       escape_mode
);
    import utf8js_pkg::*;

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    utf8js_group_t push_grp;
    utf8js_group_t head;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign cfg_ready = 1'b1;

    utf8js_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .text_end  (text_end),
        .cfg_write (cfg_valid),
        .cfg_mode  (escape_mode),
        .push      (push),
        .grp       (push_grp)
    );

    utf8js_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_grp  (push_grp),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    utf8js_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_done (text_done)
    );

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
module tb;
    import utf8js_pkg::*;

    localparam logic MODE_PLAIN  = 1'b0;
    localparam logic MODE_JSON   = 1'b1;
    localparam int   IDLE_TAIL   = 8;
    localparam int   LONG_HOLD   = 60;
    localparam int   STALL_LIMIT = 3000;
    localparam int   PHASE_ITEMS = 70;

    typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] data;
        logic       fin;
        logic       typed;
        logic [1:0] n_typed;
        logic [7:0] x0;
        logic [7:0] x1;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_done;
    } out_word_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte     = 8'h00;
    logic       text_end    = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic       escape_mode = MODE_JSON;

    utf8_json_escape_sanitizer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .text_end    (text_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .text_done   (text_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .escape_mode (escape_mode)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Directed texts; typed rows carry the words read straight off the spec.
    dir_row_t dir_rows [26] = '{
        '{ROW_BYTE, 8'h00,       1'b0, 1'b1, 2'd1, CHAR_REPLACE, 8'h00},
        '{ROW_BYTE, CHAR_QUOTE,  1'b0, 1'b1, 2'd2, CHAR_BSLASH,  CHAR_QUOTE},
        '{ROW_BYTE, CHAR_BSLASH, 1'b0, 1'b1, 2'd2, CHAR_BSLASH,  CHAR_BSLASH},
        '{ROW_BYTE, CHAR_LF,     1'b0, 1'b1, 2'd2, CHAR_BSLASH,  CHAR_N},
        '{ROW_BYTE, CHAR_CR,     1'b0, 1'b1, 2'd2, CHAR_BSLASH,  CHAR_R},
        '{ROW_BYTE, CHAR_TAB,    1'b0, 1'b1, 2'd2, CHAR_BSLASH,  CHAR_T},
        '{ROW_BYTE, CHAR_DEL,    1'b0, 1'b1, 2'd1, CHAR_REPLACE, 8'h00},
        '{ROW_BYTE, 8'hFF,       1'b0, 1'b1, 2'd1, CHAR_REPLACE, 8'h00},
        '{ROW_BYTE, CONT_LO,     1'b0, 1'b1, 2'd1, CHAR_REPLACE, 8'h00},
        // two-byte and four-byte sequences at the range edges
        '{ROW_BYTE, LEAD2_LO,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CONT_HI,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, LEAD4_HI,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, 8'h8F,       1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CONT_LO,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CONT_HI,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        // four-byte lead broken by a quote: five words
        '{ROW_BYTE, LEAD4_LO,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CONT_LO,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CONT_LO,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CHAR_QUOTE,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        // lead byte as the final byte of a text
        '{ROW_BYTE, LEAD3_LO,    1'b1, 1'b1, 2'd1, CHAR_REPLACE, 8'h00},
        // switch mode while a lead is held
        '{ROW_BYTE, LEAD2_HI,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_MODE, 8'h00,       1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CONT_LO,     1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE, CHAR_LF,     1'b0, 1'b1, 2'd1, CHAR_REPLACE, 8'h00},
        '{ROW_BYTE, CHAR_QUOTE,  1'b0, 1'b1, 2'd1, CHAR_QUOTE,   8'h00},
        '{ROW_BYTE, 8'h41,       1'b1, 1'b1, 2'd1, 8'h41,        8'h00}
    };

    logic       esc_json;
    logic [7:0] held_lead;
    logic [7:0] held_cont [2];
    int         held_cnt;
    int         held_need;
    logic [7:0] grp_bytes [$];
    out_word_t  exp_words [$];

    int         in_idle_pct   = 10;
    int         out_stall_pct = 56;
    logic       long_hold_req = 1'b0;
    int         items_sent    = 0;
    int         errors        = 0;
    int         idle_cycles   = 0;
    out_word_t  seen_word;

    function automatic int lead_len(input logic [7:0] b);
        if (b >= LEAD2_LO && b <= LEAD2_HI) return 1;
        if (b >= LEAD3_LO && b <= LEAD3_HI) return 2;
        if (b >= LEAD4_LO && b <= LEAD4_HI) return 3;
        return 0;
    endfunction

    function automatic void take_fresh(input logic [7:0] b, input logic fin);
        int need;
        need = lead_len(b);
        if (b >= CONT_LO)
        begin
            if (need == 0 || fin)
                grp_bytes.push_back(CHAR_REPLACE);
            else
            begin
                held_lead = b;
                held_cnt  = 0;
                held_need = need;
            end
        end
        else if (esc_json && (b == CHAR_QUOTE || b == CHAR_BSLASH))
        begin
            grp_bytes.push_back(CHAR_BSLASH);
            grp_bytes.push_back(b);
        end
        else if (esc_json && b == CHAR_LF)
        begin
            grp_bytes.push_back(CHAR_BSLASH);
            grp_bytes.push_back(CHAR_N);
        end
        else if (esc_json && b == CHAR_CR)
        begin
            grp_bytes.push_back(CHAR_BSLASH);
            grp_bytes.push_back(CHAR_R);
        end
        else if (esc_json && b == CHAR_TAB)
        begin
            grp_bytes.push_back(CHAR_BSLASH);
            grp_bytes.push_back(CHAR_T);
        end
        else if (b < CHAR_SPACE || b == CHAR_DEL)
            grp_bytes.push_back(CHAR_REPLACE);
        else
            grp_bytes.push_back(b);
    endfunction

    // Replace the lead and every held follower, then drop the sequence.
    function automatic void drop_held();
        grp_bytes.push_back(CHAR_REPLACE);
        for (int i = 0; i < held_cnt; i++)
            grp_bytes.push_back(CHAR_REPLACE);
        held_lead = 8'h00;
        held_cnt  = 0;
        held_need = 0;
    endfunction

    function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
        grp_bytes.delete();
        if (held_need != 0 && b >= CONT_LO && b <= CONT_HI)
        begin
            if (held_cnt + 1 >= held_need)
            begin
                grp_bytes.push_back(held_lead);
                for (int i = 0; i < held_cnt; i++)
                    grp_bytes.push_back(held_cont[i]);
                grp_bytes.push_back(b);
                held_lead = 8'h00;
                held_cnt  = 0;
                held_need = 0;
            end
            else if (!fin)
            begin
                held_cont[held_cnt] = b;
                held_cnt++;
            end
            else
            begin
                drop_held();
                take_fresh(b, fin);
            end
        end
        else
        begin
            if (held_need != 0)
                drop_held();
            take_fresh(b, fin);
        end
    endfunction

    function automatic void queue_words(input logic [7:0] bytes [$], input logic fin);
        for (int k = 0; k < bytes.size(); k++)
            exp_words.push_back('{bytes[k], k == bytes.size() - 1,
                                  (k == bytes.size() - 1) && fin});
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [1:0] n_typed, input logic [7:0] x0,
                             input logic [7:0] x1);
        logic [7:0] typed_bytes [$];
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        text_end <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sanitize_byte(b, fin);
        if (typed)
        begin
            typed_bytes.push_back(x0);
            if (n_typed == 2'd2)
                typed_bytes.push_back(x1);
            queue_words(typed_bytes, fin);
        end
        else
            queue_words(grp_bytes, fin);
        items_sent++;
    endtask

    // Drop valid and wait until the block has drained.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (exp_words.size() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        settle_idle();
        cfg_valid   <= 1'b1;
        escape_mode <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        esc_json = m;
    endtask

    // Mostly well-formed text with random content, some truncated sequences and noise.
    task automatic send_text();
        logic [7:0] txt [$];
        logic [7:0] lead;
        int         tokens;
        int         pick;
        int         len;
        int         conts;
        tokens = $urandom_range(8, 1);
        repeat (tokens)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                txt.push_back(8'($urandom_range(8'h7E, 8'h20)));
            else if (pick < 45)
            begin
                case ($urandom_range(6))
                    0: txt.push_back(CHAR_QUOTE);
                    1: txt.push_back(CHAR_BSLASH);
                    2: txt.push_back(CHAR_LF);
                    3: txt.push_back(CHAR_CR);
                    4: txt.push_back(CHAR_TAB);
                    5: txt.push_back(CHAR_DEL);
                    default: txt.push_back(8'($urandom_range(8'h1F, 8'h00)));
                endcase
            end
            else if (pick < 85)
            begin
                len = $urandom_range(3, 1);
                case (len)
                    1: lead = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
                    2: lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
                    default: lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
                endcase
                txt.push_back(lead);
                conts = (pick < 70) ? len : $urandom_range(len - 1, 0);
                repeat (conts) txt.push_back(8'($urandom_range(CONT_HI, CONT_LO)));
            end
            else
                txt.push_back(8'($urandom_range(255)));
        end
        foreach (txt[i])
            send_byte(txt[i], i == txt.size() - 1, 1'b0, 2'd0, 8'h00, 8'h00);
    endtask

    initial
    begin
        int   target;
        int   pause_at;
        logic paused;
        paused    = 1'b0;
        esc_json  = MODE_JSON;
        held_lead = 8'h00;
        held_cnt  = 0;
        held_need = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_MODE)
                write_mode(dir_rows[r].data[0]);
            else
                send_byte(dir_rows[r].data, dir_rows[r].fin, dir_rows[r].typed,
                          dir_rows[r].n_typed, dir_rows[r].x0, dir_rows[r].x1);
        end
        for (int ph = 0; ph < 3; ph++)
        begin
            write_mode((ph == 1) ? MODE_PLAIN : MODE_JSON);
            in_idle_pct   = (ph == 0) ? 10 : (ph == 1) ? 56 : 0;
            out_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 10 : 0;
            if (ph == 0)
                long_hold_req = 1'b1;
            target   = items_sent + PHASE_ITEMS;
            pause_at = items_sent + PHASE_ITEMS / 2;
            while (items_sent < target)
            begin
                send_text();
                // hold the sender until every word has drained
                if (ph == 1 && !paused && items_sent >= pause_at)
                begin
                    settle_idle();
                    paused = 1'b1;
                end
            end
        end
        settle_idle();
        if (errors == 0)
            $display("[utf8_json_escape_sanitizer_core] OK");
        else
            $display("[utf8_json_escape_sanitizer_core] ERROR");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial
    begin
        int hold_cnt;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_cnt = 0;
                while (hold_cnt < LONG_HOLD)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                    hold_cnt++;
                end
            end
            out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_words.size() == 0)
            begin
                $display("%0t: unexpected word: got %h run_last %b text_done %b",
                         $time, out_byte, run_last, text_done);
                errors++;
            end
            else
            begin
                seen_word = exp_words.pop_front();
                if (out_byte !== seen_word.data || run_last !== seen_word.run_last ||
                    text_done !== seen_word.text_done)
                begin
                    $display("%0t: word mismatch: expected %h/%b/%b got %h/%b/%b", $time,
                             seen_word.data, seen_word.run_last, seen_word.text_done,
                             out_byte, run_last, text_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[utf8_json_escape_sanitizer_core] ERROR");
            $finish;
        end
    end

endmodule

### sim.f
hdl/utf8js_pkg.sv
hdl/utf8js_front.sv
hdl/utf8js_queue.sv
hdl/utf8js_back.sv
hdl/utf8_json_escape_sanitizer_core.sv
dv/tb.sv
